// File: hw/rtl/lzwse_pkg.sv
// ----------------------------------------------------------------------------
// lzwse_pkg
// Shared constants and types for the LZW stream encoder.
// ----------------------------------------------------------------------------
package lzwse_pkg;

  // Dictionary size and the widest code.
  localparam int DICT_SLOTS     = 8192;
  localparam int MAX_CODE_WIDTH = 12;

  // Reserved codes and the starting code width.
  localparam logic [8:0] CLEAR_CODE  = 9'd256;
  localparam logic [8:0] EOD_CODE    = 9'd257;
  localparam logic [8:0] FIRST_FREE  = 9'd258;
  localparam logic [4:0] START_WIDTH = 5'd9;

  // Configuration register indexes.
  localparam logic [0:0] REG_WIDEN_EARLY = 1'b0;

  // One code handed to the bit packer.
  typedef struct packed {
    logic [15:0] value;
    logic [4:0]  width;
    logic        flush;
    logic        last;
    logic        eom;
  } pack_req_t;

endpackage

// File: hw/rtl/lzwse_ram.sv
// ----------------------------------------------------------------------------
// lzwse_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module lzwse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/lzwse_packer.sv
// ----------------------------------------------------------------------------
// lzwse_packer
// Packs variable-width codes MSB-first into bytes, one byte per beat.
// ----------------------------------------------------------------------------
module lzwse_packer
  import lzwse_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  pack_req_t req,
  input  logic      req_valid,
  output logic      req_ready,
  output logic [7:0] out_byte,
  output logic      run_last,
  output logic      message_last,
  output logic      valid,
  input  logic      ready
);

  // Bit accumulator: up to 7 leftover bits plus one 16-bit code.
  logic [22:0] acc;
  logic [4:0]  nbits;
  logic        last_q;
  logic        eom_q;
  logic        flush_q;
  logic        busy;
  logic        more;

  assign req_ready = !busy && (!valid || ready);
  assign more = (nbits >= 5'd8) || (flush_q && nbits != 5'd0);

  // Emit full bytes, then load the next code once drained.
  always_ff @(posedge clk) begin
    if (rst) begin
      nbits <= '0;
      busy  <= 1'b0;
      valid <= 1'b0;
      acc   <= '0;
    end else begin
      if (valid && ready) begin
        valid <= 1'b0;
      end
      if (busy && (!valid || ready)) begin
        if (more) begin
          out_byte <= acc[22:15];
          acc      <= {acc[14:0], 8'd0};
          nbits    <= (nbits >= 5'd8) ? nbits - 5'd8 : 5'd0;
          valid    <= 1'b1;
          run_last <= 1'b0;
          message_last <= 1'b0;
          if (!((nbits - ((nbits >= 5'd8) ? 5'd8 : nbits) >= 5'd8) ||
                (flush_q && nbits > 5'd8))) begin
            run_last     <= last_q;
            message_last <= last_q && eom_q;
            busy         <= 1'b0;
          end
        end else begin
          busy <= 1'b0;
        end
      end else if (req_valid && req_ready) begin
        acc     <= acc | ({7'd0, req.value} << (5'd23 - nbits - req.width));
        nbits   <= nbits + req.width;
        last_q  <= req.last;
        eom_q   <= req.eom;
        flush_q <= req.flush;
        busy    <= 1'b1;
      end
      if (busy && !more) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// File: hw/rtl/lzw_stream_encoder_unit.sv
// ----------------------------------------------------------------------------
// lzw_stream_encoder_unit
// LZW encoder, PDF stream form, with a hashed dictionary in one RAM.
// ----------------------------------------------------------------------------
// An input beat that changes nothing is accepted in S_IDLE and stays there. A
// data byte inside a message passes through accept, dictionary read and compare
// (S_IDLE, S_READ, S_PROBE) when its pair is found at the first probe; each
// further linear probe repeats S_PROBE. A new pair passes through S_EMIT2 or
// S_EMIT3 to queue its codes, and every queued code then goes to the packer from
// S_EMIT once the packer has sent the bytes of the code before it, one byte a
// cycle while the output is ready; the bytes of the final code drain while the
// next beat is processed. A beat that opens a message queues its codes at once.
// After reset, at the end of each message and at every table-full Clear, the
// dictionary is swept clear one slot a cycle while no input beat is accepted.
module lzw_stream_encoder_unit
  import lzwse_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       psel,
  input  logic       penable,
  input  logic       pwrite,
  input  logic [1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready,
  input  logic [7:0] byte_value,
  input  logic       byte_present,
  input  logic       end_of_message,
  input  logic       in_valid,
  output logic       in_ready,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       message_last,
  output logic       out_valid,
  input  logic       out_ready
);

  localparam int AW = $clog2(DICT_SLOTS);
  localparam int CW = MAX_CODE_WIDTH;
  localparam int KW = CW + 8;
  localparam int EW = 1 + KW + CW;
  localparam logic [CW:0] TABLE_END = (CW + 1)'(1) << CW;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_PROBE, S_EMIT, S_EMIT2, S_EMIT3
  } state_t;

  state_t state;
  state_t after_emit;
  logic widen_early;
  logic [CW-1:0] prefix;
  logic [CW:0]   free_code;
  logic [4:0]    code_width;
  logic          in_msg;
  logic [7:0]    cur_byte;
  logic          cur_eom;
  logic [AW-1:0] slot;
  logic [AW-1:0] tries;
  logic          need_clear;

  logic          we;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic [AW-1:0] raddr;
  logic [EW-1:0] rdata;

  pack_req_t req;
  logic      req_valid;
  logic      req_ready;

  logic [KW-1:0] key;
  logic          hit_valid;
  logic [KW-1:0] hit_key;
  logic [CW-1:0] hit_code;

  // Emission queue of up to four codes per beat.
  logic [15:0] q_val [4];
  logic [4:0]  q_w   [4];
  logic [2:0]  q_n;
  logic [1:0]  q_i;
  logic        q_flush;
  logic        q_eom;

  assign key       = {prefix, cur_byte};
  assign hit_valid = rdata[EW-1];
  assign hit_key   = rdata[EW-2 -: KW];
  assign hit_code  = rdata[CW-1:0];
  assign pready    = 1'b1;
  assign prdata    = {31'd0, widen_early};

  // Configuration write.
  always_ff @(posedge clk) begin
    if (rst) begin
      widen_early <= 1'b1;
    end else if (psel && penable && pwrite && paddr == 2'(REG_WIDEN_EARLY * 4)) begin
      widen_early <= pwdata[0];
    end
  end

  lzwse_ram #(.WIDTH(EW), .DEPTH(DICT_SLOTS)) u_dict (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  lzwse_packer u_pack (
    .clk(clk), .rst(rst), .req(req), .req_valid(req_valid), .req_ready(req_ready),
    .out_byte(out_byte), .run_last(run_last), .message_last(message_last),
    .valid(out_valid), .ready(out_ready)
  );

  assign in_ready = (state == S_IDLE);

  // Packer request from the queue.
  always_comb begin
    req.value = q_val[q_i];
    req.width = q_w[q_i];
    req.last  = ({1'b0, q_i} == q_n - 3'd1);
    req.flush = q_flush && req.last;
    req.eom   = q_eom;
    req_valid = (state == S_EMIT);
  end

  // Dictionary write and read ports.
  always_comb begin
    we    = 1'b0;
    waddr = slot;
    wdata = '0;
    raddr = slot;
    if (state == S_CLEAR) begin
      we = 1'b1;
    end else if (state == S_PROBE && !(hit_valid && hit_key == key) &&
                 hit_valid && tries != AW'(DICT_SLOTS - 1)) begin
      raddr = slot + AW'(1);
    end else if (state == S_PROBE && !hit_valid && !need_clear) begin
      we    = 1'b1;
      wdata = {1'b1, key, free_code[CW-1:0]};
    end
  end

  // Control sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      after_emit <= S_IDLE;
      slot       <= '0;
      prefix     <= '0;
      free_code  <= (CW + 1)'(FIRST_FREE);
      code_width <= START_WIDTH;
      in_msg     <= 1'b0;
      q_n        <= '0;
      q_i        <= '0;
      tries      <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          // The table starts over with the first free code and narrow codes.
          free_code  <= (CW + 1)'(FIRST_FREE);
          code_width <= START_WIDTH;
          slot <= slot + AW'(1);
          if (slot == AW'(DICT_SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            cur_byte <= byte_value;
            cur_eom  <= end_of_message;
            q_n      <= '0;
            q_i      <= '0;
            q_flush  <= 1'b0;
            q_eom    <= end_of_message;
            after_emit <= S_IDLE;
            if (!in_msg) begin
              if (byte_present || end_of_message) begin
                q_val[0] <= 16'(CLEAR_CODE);
                q_w[0]   <= code_width;
                q_n      <= 3'd1;
                if (byte_present) begin
                  prefix <= CW'(byte_value);
                  in_msg <= 1'b1;
                end
                if (end_of_message) begin
                  q_val[1] <= 16'(EOD_CODE);
                  q_w[1]   <= code_width;
                  q_n      <= 3'd2;
                  q_flush  <= 1'b1;
                  if (byte_present) begin
                    q_val[1] <= 16'(byte_value);
                    q_val[2] <= 16'(EOD_CODE);
                    q_w[2]   <= code_width;
                    q_n      <= 3'd3;
                  end
                  in_msg     <= 1'b0;
                  after_emit <= S_CLEAR;
                  slot       <= '0;
                end
                state <= S_EMIT;
              end
            end else if (byte_present) begin
              slot  <= AW'({prefix, byte_value} % DICT_SLOTS);
              tries <= '0;
              need_clear <= (free_code == TABLE_END);
              state <= S_READ;
            end else if (end_of_message) begin
              q_val[0] <= 16'(prefix);
              q_w[0]   <= code_width;
              q_val[1] <= 16'(EOD_CODE);
              q_w[1]   <= code_width;
              q_n      <= 3'd2;
              q_flush  <= 1'b1;
              in_msg   <= 1'b0;
              after_emit <= S_CLEAR;
              slot     <= '0;
              state    <= S_EMIT;
            end
          end
        end
        S_READ: begin
          state <= S_PROBE;
        end
        S_PROBE: begin
          if (hit_valid && hit_key == key) begin
            prefix <= hit_code;
            if (cur_eom) begin
              q_val[0] <= 16'(hit_code);
              q_w[0]   <= code_width;
              q_val[1] <= 16'(EOD_CODE);
              q_w[1]   <= code_width;
              q_n      <= 3'd2;
              q_flush  <= 1'b1;
              in_msg   <= 1'b0;
              after_emit <= S_CLEAR;
              slot     <= '0;
              state    <= S_EMIT;
            end else begin
              state <= S_IDLE;
            end
          end else if (hit_valid && tries != AW'(DICT_SLOTS - 1)) begin
            slot  <= slot + AW'(1);
            tries <= tries + AW'(1);
            state <= S_PROBE;
          end else begin
            // New pair: emit prefix, install or clear.
            q_val[0] <= 16'(prefix);
            q_w[0]   <= code_width;
            q_n      <= 3'd1;
            prefix   <= CW'(cur_byte);
            if (!need_clear) begin
              free_code <= free_code + (CW + 1)'(1);
              if (({1'b0, free_code} + 14'd1) >=
                  ((14'd1 << code_width) - 14'(widen_early)) &&
                  code_width < 5'(CW)) begin
                code_width <= code_width + 5'd1;
              end
              state <= S_EMIT2;
            end else begin
              q_val[1] <= 16'(CLEAR_CODE);
              q_w[1]   <= code_width;
              q_n      <= 3'd2;
              free_code  <= (CW + 1)'(FIRST_FREE);
              code_width <= START_WIDTH;
              after_emit <= S_CLEAR;
              slot       <= '0;
              state      <= S_EMIT3;
            end
          end
        end
        S_EMIT2: begin
          // Append the closing codes using the updated width.
          if (cur_eom) begin
            q_val[1] <= 16'(prefix);
            q_w[1]   <= code_width;
            q_val[2] <= 16'(EOD_CODE);
            q_w[2]   <= code_width;
            q_n      <= 3'd3;
            q_flush  <= 1'b1;
            in_msg   <= 1'b0;
            after_emit <= S_CLEAR;
            slot     <= '0;
          end
          state <= S_EMIT;
        end
        S_EMIT3: begin
          // After a table-full Clear the closing codes use the start width.
          if (cur_eom) begin
            q_val[2] <= 16'(prefix);
            q_w[2]   <= code_width;
            q_val[3] <= 16'(EOD_CODE);
            q_w[3]   <= code_width;
            q_n      <= 3'd4;
            q_flush  <= 1'b1;
            in_msg   <= 1'b0;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (req_ready) begin
            if ({1'b0, q_i} == q_n - 3'd1) begin
              state <= after_emit;
            end else begin
              q_i <= q_i + 2'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// LZW stream encoder testbench
// Drives byte beats into the encoder, predicts the packed code stream for
// every accepted beat and compares each output beat with the oldest
// prediction. The early widening setting is flipped between idle phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import lzwse_pkg::*;

  localparam int          CODE_BITS_MAX = MAX_CODE_WIDTH;
  localparam int          SWEEP_WAIT    = 9000;
  localparam int unsigned CYCLE_LIMIT   = 20000000;
  localparam int          IDLE_PCT      = 18;

  typedef struct {
    logic [7:0] value;
    logic       present;
    logic       eom;
  } byte_beat_t;

  typedef struct {
    logic [7:0] data;
    logic       run_end;
    logic       msg_end;
  } packed_beat_t;

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic [7:0]  byte_value = '0;
  logic        byte_present = 1'b0, end_of_message = 1'b0, in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  out_byte;
  logic        run_last, message_last, out_valid;
  logic        out_ready = 1'b0;

  lzw_stream_encoder_unit dut (.*);

  byte_beat_t   pending_beats[$];
  packed_beat_t expected_bytes[$];
  byte_beat_t   beat_on_bus;
  int           mismatches = 0;
  int unsigned  cycles = 0;
  int           beats_taken = 0;
  int           hold_left;
  int           rx_beats;

  // Encoder model state.
  int unsigned dict_map[int unsigned];
  int unsigned cur_prefix, free_code, width_now, early_mode;
  int unsigned bits_left, bits_count;
  bit          msg_open;
  logic [7:0]  enc_bytes[$];

  // Clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Cycle limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic void put_code(int unsigned value, int unsigned width);
    int unsigned acc;
    int unsigned n;
    acc = (bits_left & 8'hff) >> (8 - bits_count);
    n = bits_count + width;
    acc = (acc << width) | (value & ((1 << width) - 1));
    while (n >= 8) begin
      enc_bytes.insert(enc_bytes.size(), 8'((acc >> (n - 8)) & 8'hff));
      n -= 8;
    end
    bits_count = n;
    bits_left = ((acc & ((1 << n) - 1)) << (8 - n)) & 8'hff;
  endfunction

  function automatic void restart_table();
    dict_map.delete();
    free_code = FIRST_FREE;
    width_now = START_WIDTH;
  endfunction

  // Works out the packed bytes that one accepted beat produces.
  function automatic void encode_beat(byte_beat_t b);
    int unsigned  key;
    packed_beat_t r;
    enc_bytes.delete();
    if (!msg_open) begin
      if (!b.present && !b.eom) return;
      restart_table();
      put_code(CLEAR_CODE, width_now);
      if (b.present) begin
        cur_prefix = b.value;
        msg_open = 1'b1;
      end
    end else if (b.present) begin
      key = (cur_prefix << 8) | b.value;
      if (dict_map.exists(key)) begin
        cur_prefix = dict_map[key];
      end else begin
        put_code(cur_prefix, width_now);
        if (free_code < (1 << CODE_BITS_MAX)) begin
          dict_map[key] = free_code;
          free_code++;
          if (free_code >= (1 << width_now) - early_mode && width_now < CODE_BITS_MAX)
            width_now++;
        end else begin
          put_code(CLEAR_CODE, width_now);
          restart_table();
        end
        cur_prefix = b.value;
      end
    end
    if (b.eom) begin
      if (msg_open) put_code(cur_prefix, width_now);
      put_code(EOD_CODE, width_now);
      if (bits_count > 0) enc_bytes.insert(enc_bytes.size(), 8'(bits_left));
      bits_left = 0;
      bits_count = 0;
      msg_open = 1'b0;
      cur_prefix = 0;
      restart_table();
    end
    foreach (enc_bytes[k]) begin
      r.data    = enc_bytes[k];
      r.run_end = (k == enc_bytes.size() - 1);
      r.msg_end = r.run_end && b.eom;
      expected_bytes.insert(expected_bytes.size(), r);
    end
  endfunction

  // Long stretch with no idling on either side.
  function automatic bit idle_now();
    if (beats_taken >= 60 && beats_taken < 160) return 1'b0;
    return $urandom_range(99) < IDLE_PCT;
  endfunction

  // Input driver: holds a beat until it is taken, then predicts it.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        encode_beat(beat_on_bus);
        beats_taken <= beats_taken + 1;
      end
      if (!(in_valid && !in_ready)) begin
        if (pending_beats.size() > 0 && !idle_now()) begin
          beat_on_bus = pending_beats.pop_front();
          byte_value     <= beat_on_bus.value;
          byte_present   <= beat_on_bus.present;
          end_of_message <= beat_on_bus.eom;
          in_valid       <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output side: random back-pressure plus one long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      rx_beats  <= 0;
    end else begin
      if (in_valid && in_ready) rx_beats <= rx_beats + 1;
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (in_valid && in_ready && rx_beats == 120) begin
        hold_left <= 600;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !idle_now();
      end
    end
  end

  // Output checker.
  always @(posedge clk) begin
    packed_beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_bytes.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10)
          $display("unexpected beat: byte %h last %b msg %b", out_byte, run_last, message_last);
      end else begin
        want = expected_bytes.pop_front();
        if (out_byte !== want.data || run_last !== want.run_end ||
            message_last !== want.msg_end) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: expected %h/%b/%b got %h/%b/%b", want.data, want.run_end,
                     want.msg_end, out_byte, run_last, message_last);
        end
      end
    end
  end

  task automatic add_beat(input logic [7:0] v, input logic p, input logic e);
    byte_beat_t b;
    b.value = v;
    b.present = p;
    b.eom = e;
    pending_beats.insert(pending_beats.size(), b);
  endtask

  // Random messages; mostly a small alphabet so that matches build up.
  task automatic add_messages(input int n_items);
    int count;
    int len;
    bit narrow;
    int k;
    logic [7:0] base;
    count = 0;
    while (count < n_items) begin
      len = $urandom_range(1, 30);
      narrow = $urandom_range(99) < 70;
      base = 8'($urandom);
      if ($urandom_range(99) < 5) add_beat(8'($urandom), 1'b0, 1'b0);
      for (k = 0; k < len; k++) begin
        if ($urandom_range(99) < 8) add_beat(8'($urandom), 1'b0, 1'b0);
        if (k == len - 1 && $urandom_range(99) < 10) begin
          add_beat(8'($urandom), 1'b1, 1'b0);
          add_beat(8'($urandom), 1'b0, 1'b1);
        end else begin
          add_beat(narrow ? base + 8'($urandom_range(3)) : 8'($urandom), 1'b1, k == len - 1);
        end
        count++;
      end
    end
  endtask

  // Waits until every prediction has been met and the sweep is over.
  task automatic drain();
    @(negedge clk);
    while (pending_beats.size() > 0 || in_valid || expected_bytes.size() > 0)
      @(negedge clk);
    repeat (SWEEP_WAIT) @(posedge clk);
  endtask

  task automatic write_widen_mode(input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= 2'(REG_WIDEN_EARLY * 4);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    early_mode = value & 1;
  endtask

  // Phases of stimulus.
  initial begin
    int k;
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    restart_table();
    cur_prefix = 0; bits_left = 0; bits_count = 0; msg_open = 1'b0; early_mode = 1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    drain();

    // Directed: ignored bare beat, empty message, single extreme bytes,
    // repeats, a bare beat mid-message and a bare end marker.
    add_beat(8'hff, 1'b0, 1'b0);
    add_beat(8'h00, 1'b0, 1'b1);
    add_beat(8'h00, 1'b1, 1'b1);
    add_beat(8'hff, 1'b1, 1'b1);
    for (k = 0; k < 10; k++) add_beat(8'h41, 1'b1, 1'b0);
    add_beat(8'h5a, 1'b0, 1'b0);
    add_beat(8'h42, 1'b1, 1'b0);
    add_beat(8'h41, 1'b1, 1'b0);
    add_beat(8'h42, 1'b1, 1'b0);
    add_beat(8'hff, 1'b0, 1'b1);
    add_messages(20);
    drain();

    // PDF-style widening off; one long message takes the width to 10 bits.
    write_widen_mode(32'd0);
    for (k = 0; k < 265; k++) add_beat(8'($urandom), 1'b1, k == 264);
    add_messages(10);
    drain();

    write_widen_mode(32'd1);
    add_messages(10);
    drain();

    write_widen_mode(32'd0);
    add_messages(10);
    drain();

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
